// ===== hw/rtl/hsgd_pkg.sv =====
// Package for the hand swing gesture detector.
// Holds codes, parameter defaults, controller states and the command and status structs.
// No dependencies.
package hsgd_pkg;

  localparam int GATE_STALE_MS_DEF = 500;
  localparam int MIN_DT_MS_DEF     = 4;
  localparam int MAX_DT_MS_DEF     = 100;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_GATE   = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_SPARE  = 2'd3;

  localparam logic [2:0] VERDICT_BELOW     = 3'd0;
  localparam logic [2:0] VERDICT_FIRED     = 3'd1;
  localparam logic [2:0] VERDICT_DISABLED  = 3'd2;
  localparam logic [2:0] VERDICT_GATE      = 3'd3;
  localparam logic [2:0] VERDICT_WHEEL     = 3'd4;
  localparam logic [2:0] VERDICT_NOT_ARMED = 3'd5;
  localparam logic [2:0] VERDICT_COOLDOWN  = 3'd6;
  localparam logic [2:0] VERDICT_DISCARDED = 3'd7;

  localparam logic [2:0] REG_ENABLED       = 3'd0;
  localparam logic [2:0] REG_THRESHOLD     = 3'd1;
  localparam logic [2:0] REG_REARM         = 3'd2;
  localparam logic [2:0] REG_COOLDOWN      = 3'd3;
  localparam logic [2:0] REG_PULSE_WIDTH   = 3'd4;
  localparam logic [2:0] REG_FIRE_DELAY    = 3'd5;
  localparam logic [2:0] REG_HEAD_COMP     = 3'd6;

  localparam int CFG_W      = 14;
  localparam int CNT_W      = 5;
  localparam int AXES       = 3;
  localparam int ROOT_STEPS = 32;
  localparam int DIV_STEPS  = 16;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_SQUARE, ST_ROOT_INIT, ST_ROOT, ST_SCALE,
    ST_DIV_INIT, ST_DIV, ST_DECIDE, ST_PULSE, ST_DONE
  } state_t;

  typedef struct packed {
    logic             capture;
    logic             check;
    logic             square;
    logic             root_init;
    logic             root_step;
    logic             scale;
    logic             div_init;
    logic             div_step;
    logic             decide;
    logic             pulse;
    logic             finish;
    logic [CNT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic need_speed;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/hsgd_ctrl.sv =====
// Controller state machine of the hand swing gesture detector.
// Sequences the datapath through squaring, root, scaling, division, decision and pulse steps.
// Depends on hsgd_pkg.
module hsgd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  hsgd_pkg::status_t status,
  output hsgd_pkg::cmd_t   cmd
);
  import hsgd_pkg::*;

  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.idx    = cnt;
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        cnt_next   = '0;
        state_next = status.need_speed ? ST_SQUARE : ST_DONE;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        if (cnt == CNT_W'(AXES - 1)) begin
          cnt_next   = '0;
          state_next = ST_ROOT_INIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_ROOT_INIT: begin
        cmd.root_init = 1'b1;
        state_next    = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (cnt == CNT_W'(ROOT_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = ST_SCALE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          cnt_next   = '0;
          state_next = ST_DECIDE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_PULSE;
      end
      ST_PULSE: begin
        cmd.pulse  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/hsgd_dp.sv =====
// Datapath of the hand swing gesture detector.
// Holds configuration, history, root and division units and the output register.
// Depends on hsgd_pkg.
module hsgd_dp #(
  parameter int GATE_STALE_MS = hsgd_pkg::GATE_STALE_MS_DEF,
  parameter int MIN_DT_MS     = hsgd_pkg::MIN_DT_MS_DEF,
  parameter int MAX_DT_MS     = hsgd_pkg::MAX_DT_MS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [2:0]                 cfg_index,
  input  logic [hsgd_pkg::CFG_W-1:0] cfg_data,
  input  logic [1:0]                 operation,
  input  logic signed [23:0]         hand_x,
  input  logic signed [23:0]         hand_y,
  input  logic signed [23:0]         hand_z,
  input  logic signed [23:0]         head_x,
  input  logic signed [23:0]         head_y,
  input  logic signed [23:0]         head_z,
  input  logic                       hand_valid,
  input  logic                       head_valid,
  input  logic                       gate_open,
  input  logic                       bumper_held,
  input  logic [47:0]                time_us,
  input  hsgd_pkg::cmd_t             cmd,
  output hsgd_pkg::status_t          status,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 verdict,
  output logic [15:0]                speed_mm_s,
  output logic                       pulse_active,
  output logic                       armed,
  output logic                       new_block,
  output logic [15:0]                fire_count,
  output logic [15:0]                block_count
);
  import hsgd_pkg::*;

  localparam int DT_W = $clog2(MAX_DT_MS * 1000 + 1);
  localparam int NQ_W = 39;

  logic        enabled, head_comp;
  logic [13:0] fire_threshold, rearm_level;
  logic [10:0] cooldown;
  logic [8:0]  pulse_width, fire_delay;

  logic [1:0]         op_r;
  logic signed [23:0] hand_r [AXES];
  logic signed [23:0] head_r [AXES];
  logic               hand_ok_r, head_ok_r, gate_in_r, bumper_r;
  logic [47:0]        now_r;

  logic               have_prev, prev_head_valid;
  logic signed [23:0] prev_hand [AXES];
  logic signed [23:0] prev_head [AXES];
  logic [47:0]        prev_time, last_fire, pulse_start, pulse_end, gate_stamp;
  logic               armed_latch, block_latch, fire_seen, pulse_valid;
  logic               gate_flag, gate_seen;
  logic [15:0]        fire_cnt, block_cnt;

  logic [DT_W-1:0] dt_r, rem;
  logic            rel_r, ovf_r, nb_r, fire_r;
  logic [51:0]     sumsq;
  logic [63:0]     rv, rr, rbit;
  logic [NQ_W-1:0] nq;
  logic [15:0]     lo, quo;
  logic [2:0]      verdict_r;
  logic [15:0]     speed_r;

  logic [47:0] dt_full, gate_age, cool_age;
  logic        window_ok;
  logic [1:0]  ax;
  logic signed [25:0] dhand, dhead, dsum;
  logic [25:0] mag;
  logic [51:0] sq;
  logic [63:0] rtest;
  logic [61:0] prod;
  logic [DT_W:0] dtry;
  logic [15:0] v;
  logic        rearm_now, arm_e, blk_e, gate_bad, cool_hit, blocked, fire_now;
  logic [2:0]  verdict_d;
  logic [20:0] cool_us;
  logic [19:0] delay_us, width_us;
  logic [48:0] start_sum, end_sum;
  logic [13:0] cfg_thr, cfg_rearm;
  logic [10:0] cfg_cool;
  logic [8:0]  cfg_width, cfg_delay;

  assign cfg_thr   = (cfg_data < 14'd300) ? 14'd300 :
                     ((cfg_data > 14'd10000) ? 14'd10000 : cfg_data);
  assign cfg_rearm = (cfg_data < 14'd50) ? 14'd50 :
                     ((cfg_data > 14'd9000) ? 14'd9000 : cfg_data);
  assign cfg_cool  = (cfg_data > 14'd2000) ? 11'd2000 : cfg_data[10:0];
  assign cfg_width = (cfg_data < 14'd20) ? 9'd20 :
                     ((cfg_data > 14'd500) ? 9'd500 : cfg_data[8:0]);
  assign cfg_delay = (cfg_data > 14'd400) ? 9'd400 : cfg_data[8:0];

  assign dt_full   = now_r - prev_time;
  assign window_ok = have_prev && dt_full >= 48'(MIN_DT_MS * 1000) &&
                     dt_full <= 48'(MAX_DT_MS * 1000);
  assign status.need_speed = (op_r == OP_SAMPLE) && hand_ok_r && window_ok;
  assign status.out_free   = !out_valid || out_ready;

  assign ax    = cmd.idx[1:0];
  assign dhand = {{2{hand_r[ax][23]}}, hand_r[ax]} - {{2{prev_hand[ax][23]}}, prev_hand[ax]};
  assign dhead = {{2{head_r[ax][23]}}, head_r[ax]} - {{2{prev_head[ax][23]}}, prev_head[ax]};
  assign dsum  = rel_r ? (dhand - dhead) : dhand;
  assign mag   = dsum[25] ? 26'(-dsum) : 26'(dsum);
  assign sq    = mag * mag;

  assign rtest = rr + rbit;
  assign prod  = rr[31:0] * 30'd1000000000;
  assign dtry  = {rem, lo[15]};

  assign v         = ovf_r ? 16'hFFFF : quo;
  assign rearm_now = (v < {2'b00, rearm_level}) &&
                     ((20'(v) * 20'd10) < (20'(fire_threshold) * 20'd9));
  assign arm_e     = armed_latch || rearm_now;
  assign blk_e     = block_latch && !rearm_now;
  assign gate_age  = now_r - gate_stamp;
  assign gate_bad  = !gate_flag || !gate_seen || gate_age > 48'(GATE_STALE_MS * 1000);
  assign cool_us   = 21'(cooldown) * 21'd1000;
  assign cool_age  = now_r - last_fire;
  assign cool_hit  = fire_seen && cool_age < 48'(cool_us);
  assign delay_us  = 20'(fire_delay) * 20'd1000;
  assign width_us  = 20'(pulse_width) * 20'd1000;
  assign start_sum = {1'b0, now_r} + 49'(delay_us);
  assign end_sum   = {1'b0, pulse_start} + 49'(width_us);

  always_comb begin
    blocked  = 1'b1;
    fire_now = 1'b0;
    priority if (v < {2'b00, fire_threshold}) begin
      verdict_d = VERDICT_BELOW;
      blocked   = 1'b0;
    end else if (!enabled) begin
      verdict_d = VERDICT_DISABLED;
    end else if (gate_bad) begin
      verdict_d = VERDICT_GATE;
    end else if (bumper_r) begin
      verdict_d = VERDICT_WHEEL;
    end else if (!arm_e) begin
      verdict_d = VERDICT_NOT_ARMED;
    end else if (cool_hit) begin
      verdict_d = VERDICT_COOLDOWN;
    end else begin
      verdict_d = VERDICT_FIRED;
      blocked   = 1'b0;
      fire_now  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled         <= 1'b1;
      fire_threshold  <= 14'd3600;
      rearm_level     <= 14'd1000;
      cooldown        <= 11'd300;
      pulse_width     <= 9'd120;
      fire_delay      <= 9'd0;
      head_comp       <= 1'b1;
      have_prev       <= 1'b0;
      prev_head_valid <= 1'b0;
      armed_latch     <= 1'b1;
      block_latch     <= 1'b0;
      fire_seen       <= 1'b0;
      pulse_valid     <= 1'b0;
      gate_flag       <= 1'b0;
      gate_seen       <= 1'b0;
      fire_cnt        <= '0;
      block_cnt       <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ENABLED: begin
            enabled <= cfg_data[0];
            if (!cfg_data[0]) pulse_valid <= 1'b0;
          end
          REG_THRESHOLD:     fire_threshold <= cfg_thr;
          REG_REARM:         rearm_level    <= cfg_rearm;
          REG_COOLDOWN:      cooldown       <= cfg_cool;
          REG_PULSE_WIDTH:   pulse_width    <= cfg_width;
          REG_FIRE_DELAY:    fire_delay     <= cfg_delay;
          REG_HEAD_COMP:     head_comp      <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.decide) begin
        if (fire_now) begin
          armed_latch <= 1'b0;
          block_latch <= 1'b1;
          fire_seen   <= 1'b1;
          pulse_valid <= 1'b1;
          fire_cnt    <= fire_cnt + 1'b1;
        end else begin
          armed_latch <= arm_e;
          if (blocked && !blk_e) begin
            block_latch <= 1'b1;
            block_cnt   <= block_cnt + 1'b1;
          end else begin
            block_latch <= blk_e;
          end
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (op_r == OP_GATE) begin
          gate_flag <= gate_in_r;
          gate_seen <= 1'b1;
        end else if (op_r == OP_SAMPLE) begin
          have_prev <= hand_ok_r;
          if (hand_ok_r) prev_head_valid <= head_ok_r;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= operation;
      hand_r[0] <= hand_x;
      hand_r[1] <= hand_y;
      hand_r[2] <= hand_z;
      head_r[0] <= head_x;
      head_r[1] <= head_y;
      head_r[2] <= head_z;
      hand_ok_r <= hand_valid;
      head_ok_r <= head_valid;
      gate_in_r <= gate_open;
      bumper_r  <= bumper_held;
      now_r     <= time_us;
      nb_r      <= 1'b0;
      fire_r    <= 1'b0;
    end
    if (cmd.check) begin
      dt_r  <= DT_W'(dt_full);
      rel_r <= head_comp && head_ok_r && prev_head_valid;
      sumsq <= '0;
    end
    if (cmd.square) sumsq <= sumsq + sq;
    if (cmd.root_init) begin
      rv   <= {2'b00, sumsq, 10'b0};
      rr   <= '0;
      rbit <= 64'h4000_0000_0000_0000;
    end
    if (cmd.root_step) begin
      if (rv >= rtest) begin
        rv <= rv - rtest;
        rr <= (rr >> 1) + rbit;
      end else begin
        rr <= rr >> 1;
      end
      rbit <= rbit >> 2;
    end
    if (cmd.scale) nq <= prod[61:23];
    if (cmd.div_init) begin
      ovf_r <= nq >= NQ_W'({dt_r, 16'b0});
      rem   <= DT_W'(nq[NQ_W-1:16]);
      lo    <= nq[15:0];
      quo   <= '0;
    end
    if (cmd.div_step) begin
      if (dtry >= {1'b0, dt_r}) begin
        rem <= DT_W'(dtry - {1'b0, dt_r});
        quo <= {quo[14:0], 1'b1};
      end else begin
        rem <= DT_W'(dtry);
        quo <= {quo[14:0], 1'b0};
      end
      lo <= {lo[14:0], 1'b0};
    end
    if (cmd.decide) begin
      verdict_r <= verdict_d;
      speed_r   <= v;
      nb_r      <= blocked && !blk_e;
      fire_r    <= fire_now;
      if (fire_now) begin
        last_fire   <= now_r;
        pulse_start <= start_sum[48] ? 48'hFFFF_FFFF_FFFF : start_sum[47:0];
      end
    end
    if (cmd.pulse && fire_r) begin
      pulse_end <= end_sum[48] ? 48'hFFFF_FFFF_FFFF : end_sum[47:0];
    end
    if (cmd.finish) begin
      if (op_r == OP_GATE) gate_stamp <= now_r;
      if (op_r == OP_SAMPLE && hand_ok_r) begin
        for (int i = 0; i < AXES; i++) begin
          prev_hand[i] <= hand_r[i];
          if (head_ok_r) prev_head[i] <= head_r[i];
        end
        prev_time <= now_r;
      end
      if (op_r != OP_SAMPLE) begin
        verdict    <= VERDICT_BELOW;
        speed_mm_s <= '0;
        new_block  <= 1'b0;
      end else if (!status.need_speed) begin
        verdict    <= VERDICT_DISCARDED;
        speed_mm_s <= '0;
        new_block  <= 1'b0;
      end else begin
        verdict    <= verdict_r;
        speed_mm_s <= speed_r;
        new_block  <= nb_r;
      end
      pulse_active <= pulse_valid && now_r < pulse_end && now_r >= pulse_start;
      armed        <= armed_latch;
      fire_count   <= fire_cnt;
      block_count  <= block_cnt;
    end
  end

endmodule

// ===== hw/rtl/hand_swing_gesture_detector_unit.sv =====
// Top level of the hand swing gesture detector.
// Joins the controller and the datapath. Depends on hsgd_pkg, hsgd_ctrl and hsgd_dp.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   operation .. time_us
//   out      output     out_valid / out_ready verdict .. block_count
//   cfg      input      cfg_write             cfg_index, cfg_data
//
// A speed sample runs through three squaring steps, 32 steps of the
// square-root unit and 16 steps of the divider.
// Gate publishes, pulse queries and discarded samples go from the check straight to the result.
// Reset is synchronous; no clearing pass follows it.
// A result waits in the output register while the next transaction is taken;
// a further result waits in the controller until the output register frees.
module hand_swing_gesture_detector_unit #(
  parameter int GATE_STALE_MS = hsgd_pkg::GATE_STALE_MS_DEF,
  parameter int MIN_DT_MS     = hsgd_pkg::MIN_DT_MS_DEF,
  parameter int MAX_DT_MS     = hsgd_pkg::MAX_DT_MS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [2:0]                 cfg_index,
  input  logic [hsgd_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 operation,
  input  logic signed [23:0]         hand_x,
  input  logic signed [23:0]         hand_y,
  input  logic signed [23:0]         hand_z,
  input  logic signed [23:0]         head_x,
  input  logic signed [23:0]         head_y,
  input  logic signed [23:0]         head_z,
  input  logic                       hand_valid,
  input  logic                       head_valid,
  input  logic                       gate_open,
  input  logic                       bumper_held,
  input  logic [47:0]                time_us,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 verdict,
  output logic [15:0]                speed_mm_s,
  output logic                       pulse_active,
  output logic                       armed,
  output logic                       new_block,
  output logic [15:0]                fire_count,
  output logic [15:0]                block_count
);
  import hsgd_pkg::*;

  cmd_t    cmd;
  status_t status;

  hsgd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  hsgd_dp #(
    .GATE_STALE_MS (GATE_STALE_MS),
    .MIN_DT_MS     (MIN_DT_MS),
    .MAX_DT_MS     (MAX_DT_MS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .operation    (operation),
    .hand_x       (hand_x),
    .hand_y       (hand_y),
    .hand_z       (hand_z),
    .head_x       (head_x),
    .head_y       (head_y),
    .head_z       (head_z),
    .hand_valid   (hand_valid),
    .head_valid   (head_valid),
    .gate_open    (gate_open),
    .bumper_held  (bumper_held),
    .time_us      (time_us),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .verdict      (verdict),
    .speed_mm_s   (speed_mm_s),
    .pulse_active (pulse_active),
    .armed        (armed),
    .new_block    (new_block),
    .fire_count   (fire_count),
    .block_count  (block_count)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a transaction is in work");

  a_block_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && new_block) |-> (verdict == VERDICT_DISABLED ||
      verdict == VERDICT_GATE || verdict == VERDICT_WHEEL ||
      verdict == VERDICT_NOT_ARMED || verdict == VERDICT_COOLDOWN))
    else $error("block counted for a verdict that is not a block");

  a_fire_disarms: assert property (@(posedge clk) disable iff (rst)
    (out_valid && verdict == VERDICT_FIRED) |-> !armed)
    else $error("detector still armed after a fire");

  a_discard_no_speed: assert property (@(posedge clk) disable iff (rst)
    (out_valid && verdict == VERDICT_DISCARDED) |-> (speed_mm_s == 16'd0))
    else $error("discarded sample reports a speed");

endmodule

// ===== bench/hsgd_checker.sv =====
// Checker for the hand swing gesture detector: watches the config port and both channels,
// predicts each result and compares it with what the block returns.
// Depends on hsgd_pkg.
module hsgd_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [2:0]                 cfg_index,
  input  logic [hsgd_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [1:0]                 operation,
  input  logic signed [23:0]         hand_x,
  input  logic signed [23:0]         hand_y,
  input  logic signed [23:0]         hand_z,
  input  logic signed [23:0]         head_x,
  input  logic signed [23:0]         head_y,
  input  logic signed [23:0]         head_z,
  input  logic                       hand_valid,
  input  logic                       head_valid,
  input  logic                       gate_open,
  input  logic                       bumper_held,
  input  logic [47:0]                time_us,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [2:0]                 verdict,
  input  logic [15:0]                speed_mm_s,
  input  logic                       pulse_active,
  input  logic                       armed,
  input  logic                       new_block,
  input  logic [15:0]                fire_count,
  input  logic [15:0]                block_count,
  output int                         errors,
  output int                         pending
);
  import hsgd_pkg::*;

  localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [15:0] speed;
    logic        pulse;
    logic        armed;
    logic        new_block;
    logic [15:0] fires;
    logic [15:0] blocks;
  } swing_result_t;

  swing_result_t expected_results[$];

  logic        en_r, head_rel_r;
  logic [13:0] thresh_r, rearm_r;
  logic [10:0] cooldown_r;
  logic [8:0]  width_r, delay_r;

  logic               seeded, last_head_ok, armed_l, blocked_l;
  logic signed [23:0] last_hand [3];
  logic signed [23:0] last_head [3];
  logic [47:0]        last_time, fire_time, pulse_start, pulse_end, gate_time;
  logic               fired_once, pulse_open, gate_val, gate_known;
  logic [15:0]        fires, blocks;

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [47:0] add_sat48(input logic [47:0] a, input longint unsigned b);
    logic [48:0] s;
    s = {1'b0, a} + b[48:0];
    return s[48] ? TIME_MAX : s[47:0];
  endfunction

  function automatic logic [13:0] clamp14(input logic [13:0] v, input int lo, input int hi);
    if (int'(v) < lo) return lo[13:0];
    if (int'(v) > hi) return hi[13:0];
    return v;
  endfunction

  function automatic logic count_block();
    if (blocked_l) return 1'b0;
    blocked_l = 1'b1;
    blocks = blocks + 16'd1;
    return 1'b1;
  endfunction

  function automatic swing_result_t evaluate_swing(input logic [47:0] now);
    swing_result_t      res;
    logic signed [23:0] hand [3];
    logic signed [23:0] head [3];
    logic [47:0]        dt;
    longint             d;
    longint unsigned    s, m, r, v;
    logic               rel;
    res = '0;
    hand[0] = hand_x; hand[1] = hand_y; hand[2] = hand_z;
    head[0] = head_x; head[1] = head_y; head[2] = head_z;
    if (operation == OP_GATE) begin
      gate_val = gate_open;
      gate_time = now;
      gate_known = 1'b1;
    end else if (operation == OP_SAMPLE) begin
      res.verdict = VERDICT_DISCARDED;
      if (!hand_valid) begin
        seeded = 1'b0;
      end else begin
        dt = now - last_time;
        if (seeded && dt >= 48'(MIN_DT_MS_DEF * 1000) &&
            dt <= 48'(MAX_DT_MS_DEF * 1000)) begin
          s = 64'd0;
          rel = head_rel_r && head_valid && last_head_ok;
          for (int i = 0; i < 3; i++) begin
            d = longint'(hand[i]) - longint'(last_hand[i]);
            if (rel) d = d - (longint'(head[i]) - longint'(last_head[i]));
            m = (d < 0) ? longint'(-d) : d;
            s = s + m * m;
          end
          r = floor_root(s << 10);
          v = (r * 64'd1000000000) / (64'(dt) << 23);
          if (v > 64'd65535) v = 64'd65535;
          res.speed = v[15:0];
          if (v < 64'(rearm_r) && 64'd10 * v < 64'd9 * 64'(thresh_r)) begin
            armed_l = 1'b1;
            blocked_l = 1'b0;
          end
          if (v < 64'(thresh_r)) begin
            res.verdict = VERDICT_BELOW;
          end else if (!en_r) begin
            res.verdict = VERDICT_DISABLED;
            res.new_block = count_block();
          end else if (!gate_val || !gate_known ||
                       48'(now - gate_time) > 48'(GATE_STALE_MS_DEF * 1000)) begin
            res.verdict = VERDICT_GATE;
            res.new_block = count_block();
          end else if (bumper_held) begin
            res.verdict = VERDICT_WHEEL;
            res.new_block = count_block();
          end else if (!armed_l) begin
            res.verdict = VERDICT_NOT_ARMED;
            res.new_block = count_block();
          end else if (fired_once && 48'(now - fire_time) < 48'(cooldown_r) * 48'd1000) begin
            res.verdict = VERDICT_COOLDOWN;
            res.new_block = count_block();
          end else begin
            res.verdict = VERDICT_FIRED;
            armed_l = 1'b0;
            blocked_l = 1'b1;
            fire_time = now;
            fired_once = 1'b1;
            pulse_start = add_sat48(now, 64'(delay_r) * 64'd1000);
            pulse_end = add_sat48(pulse_start, 64'(width_r) * 64'd1000);
            pulse_open = 1'b1;
            fires = fires + 16'd1;
          end
        end
        for (int i = 0; i < 3; i++) last_hand[i] = hand[i];
        last_head_ok = head_valid;
        if (head_valid) for (int i = 0; i < 3; i++) last_head[i] = head[i];
        last_time = now;
        seeded = 1'b1;
      end
    end
    res.pulse = pulse_open && now < pulse_end && now >= pulse_start;
    res.armed = armed_l;
    res.fires = fires;
    res.blocks = blocks;
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    swing_result_t exp_r;
    if (rst) begin
      en_r <= 1'b1; thresh_r <= 14'd3600; rearm_r <= 14'd1000; cooldown_r <= 11'd300;
      width_r <= 9'd120; delay_r <= 9'd0; head_rel_r <= 1'b1;
      seeded = 1'b0; last_head_ok = 1'b0; armed_l = 1'b1; blocked_l = 1'b0;
      for (int i = 0; i < 3; i++) begin
        last_hand[i] = '0;
        last_head[i] = '0;
      end
      last_time = '0; fire_time = '0; pulse_start = '0; pulse_end = '0; gate_time = '0;
      fired_once = 1'b0; pulse_open = 1'b0; gate_val = 1'b0; gate_known = 1'b0;
      fires = '0; blocks = '0;
      errors = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result transaction with none expected, verdict %0d", $time, verdict);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("verdict", 16'(exp_r.verdict), 16'(verdict));
          check_field("speed_mm_s", exp_r.speed, speed_mm_s);
          check_field("pulse_active", 16'(exp_r.pulse), 16'(pulse_active));
          check_field("armed", 16'(exp_r.armed), 16'(armed));
          check_field("new_block", 16'(exp_r.new_block), 16'(new_block));
          check_field("fire_count", exp_r.fires, fire_count);
          check_field("block_count", exp_r.blocks, block_count);
        end
      end
      if (in_valid && in_ready) expected_results.push_back(evaluate_swing(time_us));
      if (cfg_write) begin
        case (cfg_index)
          REG_ENABLED: begin
            en_r <= cfg_data[0];
            if (!cfg_data[0]) begin
              pulse_open = 1'b0;
              pulse_start = '0;
              pulse_end = '0;
            end
          end
          REG_THRESHOLD:     thresh_r <= clamp14(cfg_data, 300, 10000);
          REG_REARM:         rearm_r <= clamp14(cfg_data, 50, 9000);
          REG_COOLDOWN:      cooldown_r <= 11'(clamp14(cfg_data, 0, 2000));
          REG_PULSE_WIDTH:   width_r <= 9'(clamp14(cfg_data, 20, 500));
          REG_FIRE_DELAY:    delay_r <= 9'(clamp14(cfg_data, 0, 400));
          REG_HEAD_COMP:     head_rel_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
    pending = expected_results.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the testbench for the hand swing gesture detector: clock, reset, stimulus,
// receiver stalls, watchdog and verdict. Depends on hsgd_pkg, hsgd_checker and the block.
module tb_top;
  import hsgd_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int LONG_HOLD  = 400;

  logic               clk, rst;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  logic               in_valid, in_ready;
  logic [1:0]         operation;
  logic signed [23:0] hand_x, hand_y, hand_z, head_x, head_y, head_z;
  logic               hand_valid, head_valid, gate_open, bumper_held;
  logic [47:0]        time_us;
  logic               out_valid, out_ready;
  logic [2:0]         verdict;
  logic [15:0]        speed_mm_s, fire_count, block_count;
  logic               pulse_active, armed, new_block;
  int                 errors, pending;

  logic               in_taken;
  int                 idle_cycles;
  int                 send_idle_pct, recv_idle_pct;
  bit                 hold_long;
  logic signed [23:0] hand_pos [3];
  logic signed [23:0] head_pos [3];
  logic [47:0]        t_now;

  hand_swing_gesture_detector_unit u_dut (.*);

  hsgd_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int gap_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
  endfunction

  initial begin
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_long = 1'b0;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
        out_ready <= 1'b0;
        repeat (gap_length()) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Called and returns at a falling edge; one transaction per call.
  task automatic send_item(input logic [1:0] op, input logic hv, input logic gv,
                           input logic go, input logic bh);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat (gap_length()) @(negedge clk);
    end
    operation <= op;
    hand_x <= hand_pos[0]; hand_y <= hand_pos[1]; hand_z <= hand_pos[2];
    head_x <= head_pos[0]; head_y <= head_pos[1]; head_z <= head_pos[2];
    hand_valid <= hv; head_valid <= gv; gate_open <= go; bumper_held <= bh;
    time_us <= t_now;
    in_valid <= 1'b1;
    do @(negedge clk); while (!in_taken);
  endtask

  task automatic swing(input int dt_us, input int dx, input logic bh);
    t_now = t_now + 48'(dt_us);
    hand_pos[0] = hand_pos[0] + 24'(dx);
    send_item(OP_SAMPLE, 1'b1, 1'b1, 1'b0, bh);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic random_item();
    int   pick, scale;
    logic op2;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      t_now = t_now + 48'($urandom_range(0, 5000));
      send_item(OP_GATE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                $urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)));
    end else if (pick < 20) begin
      op2 = 1'($urandom_range(0, 1));
      t_now = t_now + 48'($urandom_range(0, 40000));
      send_item(op2 ? OP_SPARE : OP_QUERY, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end else if (pick < 23) begin
      t_now = t_now + 48'($urandom_range(4000, 20000));
      send_item(OP_SAMPLE, 1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end else if (pick < 27) begin
      for (int i = 0; i < 3; i++) begin
        hand_pos[i] = 24'($urandom);
        head_pos[i] = 24'($urandom);
      end
      if ($urandom_range(0, 1) == 0) t_now = {16'($urandom), 32'($urandom)};
      send_item(OP_SAMPLE, 1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 85) t_now = t_now + 48'($urandom_range(6000, 30000));
      else if (pick < 91) t_now = t_now + 48'($urandom_range(0, 3999));
      else if (pick < 97) t_now = t_now + 48'($urandom_range(100001, 700000));
      else t_now = t_now - 48'($urandom_range(1, 50000));
      case ($urandom_range(0, 2))
        0: scale = 500;
        1: scale = 6000;
        default: scale = 40000;
      endcase
      for (int i = 0; i < 3; i++) begin
        hand_pos[i] = hand_pos[i] + 24'($urandom_range(0, 2 * scale)) - 24'(scale);
        head_pos[i] = head_pos[i] + 24'($urandom_range(0, 4000)) - 24'(2000);
      end
      send_item(OP_SAMPLE, 1'b1, $urandom_range(0, 7) != 0, 1'b0,
                $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    int regs [6][7];
    rst = 1'b1;
    cfg_write = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; operation = OP_SAMPLE;
    hand_x = '0; hand_y = '0; hand_z = '0; head_x = '0; head_y = '0; head_z = '0;
    hand_valid = 1'b0; head_valid = 1'b0; gate_open = 1'b0; bumper_held = 1'b0;
    time_us = '0;
    hold_long = 1'b0;
    send_idle_pct = 30; recv_idle_pct = 30;
    for (int i = 0; i < 3; i++) begin
      hand_pos[i] = '0;
      head_pos[i] = '0;
    end
    t_now = 48'd1000;
    regs = '{'{1, 300, 50, 0, 20, 0, 0},
             '{1, 10000, 9000, 2000, 500, 400, 1},
             '{1, 0, 16383, 2047, 511, 511, 1},
             '{0, 3600, 1000, 300, 120, 0, 1},
             '{1, 0, 0, 0, 0, 0, 0},
             '{1, 1500, 2000, 100, 60, 50, 1}};
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    swing(0, 0, 1'b0);
    send_item(OP_GATE, 1'b1, 1'b1, 1'b1, 1'b0);
    swing(10000, 20000, 1'b0);
    t_now = t_now + 48'd30000;
    send_item(OP_QUERY, 1'b1, 1'b1, 1'b0, 1'b0);
    swing(10000, 50, 1'b0);
    swing(10000, 20000, 1'b0);
    swing(10000, 20000, 1'b0);
    swing(10000, 50, 1'b0);
    swing(10000, 20000, 1'b1);
    swing(10000, 50, 1'b0);
    swing(300000, 50, 1'b0);
    swing(2000, 50, 1'b0);
    swing(10000, 20000, 1'b0);
    send_item(OP_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_item(OP_SPARE, 1'b0, 1'b0, 1'b0, 1'b0);
    send_item(OP_GATE, 1'b0, 1'b0, 1'b0, 1'b0);
    swing(10000, 0, 1'b0);
    swing(10000, 20000, 1'b0);
    send_item(OP_GATE, 1'b1, 1'b1, 1'b1, 1'b0);
    for (int i = 0; i < 3; i++) hand_pos[i] = 24'h7FFFFF;
    swing(10000, 0, 1'b0);
    for (int i = 0; i < 3; i++) hand_pos[i] = 24'h800000;
    swing(400000, 0, 1'b0);
    for (int i = 0; i < 3; i++) begin
      hand_pos[i] = hand_pos[i] + 24'd30000;
      head_pos[i] = head_pos[i] + 24'd30000;
    end
    swing(10000, 0, 1'b0);
    t_now = 48'hFFFF_FFFF_FFFF - 48'd20000;
    send_item(OP_GATE, 1'b1, 1'b1, 1'b1, 1'b0);
    swing(10000, 0, 1'b0);
    swing(10000, 30000, 1'b0);
    swing(20000, 50, 1'b0);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      for (int r = 0; r < 7; r++) begin
        if (p == 4) begin
          case (r)
            0, 6: regs[p][r] = $urandom_range(0, 1);
            1: regs[p][r] = $urandom_range(300, 10000);
            2: regs[p][r] = $urandom_range(50, 9000);
            3: regs[p][r] = $urandom_range(0, 2000);
            4: regs[p][r] = $urandom_range(20, 500);
            default: regs[p][r] = $urandom_range(0, 400);
          endcase
          regs[p][0] = 1;
        end
        write_reg(3'(r), regs[p][r]);
      end
      send_idle_pct = (p == 1) ? 0 : 25;
      recv_idle_pct = (p == 1) ? 0 : 25;
      if (p == 0) hold_long = 1'b1;
      for (int n = 0; n < 66; n++) random_item();
    end
    wait_drained();
    write_reg(REG_ENABLED, 1);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== hand_swing_gesture_detector_unit.f =====
hw/rtl/hsgd_pkg.sv
hw/rtl/hsgd_ctrl.sv
hw/rtl/hsgd_dp.sv
hw/rtl/hand_swing_gesture_detector_unit.sv
bench/hsgd_checker.sv
bench/tb_top.sv
